@@ hdl/d2s_pkg.sv @@
package d2s_pkg;
   localparam logic [63:0] FLT_MAX_BITS64 = 64'h47EF_FFFF_E000_0000;
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QAW = $clog2(QDEPTH);

   typedef enum logic [1:0] {
      ST_CONVERTED = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_SKIPPED   = 2'd2
   } status_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [63:0] value;
      status_type  status;
      logic        last;
   } item_type;

   // round right shift to nearest even, sh in 1..63
   function automatic logic [53:0] round_shift(input logic [52:0] m, input logic [5:0] sh);
      logic [115:0] wide;
      logic [52:0]  keep;
      logic         guard;
      logic         sticky;
      wide   = {m, 63'd0} >> sh;
      keep   = wide[115:63];
      guard  = wide[62];
      sticky = |wide[61:0];
      return {1'b0, keep} + 54'(guard & (sticky | keep[0]));
   endfunction
endpackage

@@ hdl/d2s_front.sv @@
module d2s_front import d2s_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_value_bits,
   input  logic        req_last_element,
   output logic        q_valid,
   input  logic        q_full,
   output item_type    q_item
);
   logic     aborted_ff, aborted_in;
   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take, is_nan, ovf;

   assign req_full = valid_ff & q_full;
   assign take     = req_push & ~req_full;
   assign q_valid  = valid_ff;
   assign q_item   = item_ff;

   // classify the request against the abort flag and FLT_MAX, and update the abort flag
   always_comb begin
      is_nan = (req_value_bits[62:52] == 11'h7FF) && (req_value_bits[51:0] != 52'd0);
      ovf    = ~is_nan && ({1'b0, req_value_bits[62:0]} > FLT_MAX_BITS64);
      item_in       = item_ff;
      valid_in      = valid_ff & q_full;
      aborted_in    = aborted_ff;
      if (take) begin
         valid_in        = 1'b1;
         item_in.value   = req_value_bits;
         item_in.last    = req_last_element;
         if (aborted_ff)  item_in.status = ST_SKIPPED;
         else if (ovf)    item_in.status = ST_OVERFLOW;
         else             item_in.status = ST_CONVERTED;
         if (!aborted_ff && ovf) aborted_in = 1'b1;
         if (req_last_element)   aborted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aborted_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         aborted_ff <= aborted_in;
         valid_ff   <= valid_in;
      end
      item_ff <= item_in;
   end
endmodule

@@ hdl/d2s_queue.sv @@
module d2s_queue import d2s_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_full,
   input  item_type wr_item,
   output logic     rd_valid,
   input  logic     rd_take,
   output item_type rd_item
);
   item_type      mem_ff [QDEPTH];
   logic [QAW:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic          push, pop;

   assign wr_full  = (wptr_ff[QAW] != rptr_ff[QAW]) && (wptr_ff[QAW-1:0] == rptr_ff[QAW-1:0]);
   assign rd_valid = wptr_ff != rptr_ff;
   assign rd_item  = mem_ff[rptr_ff[QAW-1:0]];
   assign push     = wr_valid & ~wr_full;
   assign pop      = rd_take & rd_valid;
   assign wptr_in  = wptr_ff + (QAW+1)'(push);
   assign rptr_in  = rptr_ff + (QAW+1)'(pop);

   // pointer update and queue write
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
      if (push) mem_ff[wptr_ff[QAW-1:0]] <= wr_item;
   end
endmodule

@@ hdl/d2s_back.sv @@
module d2s_back import d2s_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_take,
   input  item_type    q_item,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_single_bits,
   output logic [1:0]  rsp_status,
   output logic        rsp_end_of_matrix
);
   logic        valid_ff, valid_in;
   logic [31:0] bits_ff, bits_in;
   logic [1:0]  status_ff;
   logic        last_ff;
   logic [31:0] conv;
   logic [10:0] ex;
   logic [52:0] m;
   logic [53:0] r;
   logic [11:0] sh;
   logic        sgn;

   assign rsp_empty         = ~valid_ff;
   assign q_take            = q_valid & (~valid_ff | rsp_pop);
   assign rsp_single_bits   = bits_ff;
   assign rsp_status        = status_ff;
   assign rsp_end_of_matrix = last_ff;
   assign valid_in          = q_take | (valid_ff & ~rsp_pop);

   // rebias exponent and round the significand
   always_comb begin
      sgn  = q_item.value[63];
      ex   = q_item.value[62:52];
      m    = {1'b1, q_item.value[51:0]};
      sh   = 12'd926 - {1'b0, ex};
      r    = round_shift(m, 6'd29);
      conv = {sgn, 31'd0};
      if (ex == 11'h7FF) begin
         conv = {sgn, 8'hFF, 1'b1, q_item.value[50:29]};
      end else if (ex == 11'd0) begin
         conv = {sgn, 31'd0};
      end else if (ex > 11'd896) begin
         conv = {sgn, 31'(({20'd0, ex - 11'd896} << 23) + 31'(r) - 31'h0080_0000)};
      end else if (sh < 12'd54) begin
         r    = round_shift(m, sh[5:0]);
         conv = {sgn, r[30:0]};
      end
      bits_in = (q_item.status == ST_CONVERTED) ? conv : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (q_take) begin
         bits_ff   <= bits_in;
         status_ff <= q_item.status;
         last_ff   <= q_item.last;
      end
   end
endmodule

@@ hdl/double_to_single_convert_checked.sv @@
// path: an accepted request passes the front register, a queue entry and the result register
// throughput: one request per cycle while req_full is low; front register, 4-entry queue, result register
// a full queue plus an item held in the front register stalls the front via req_full
// reset: synchronous active high; clears abort flag, queue and valid state
module double_to_single_convert_checked import d2s_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_value_bits,
   input  logic        req_last_element,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_single_bits,
   output logic [1:0]  rsp_status,
   output logic        rsp_end_of_matrix
);
   logic     f_valid, f_full, b_valid, b_take;
   item_type f_item, b_item;

   d2s_front u_front (
      .clock, .reset, .req_push, .req_full, .req_value_bits, .req_last_element,
      .q_valid(f_valid), .q_full(f_full), .q_item(f_item)
   );

   d2s_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_full(f_full), .wr_item(f_item),
      .rd_valid(b_valid), .rd_take(b_take), .rd_item(b_item)
   );

   d2s_back u_back (
      .clock, .reset, .q_valid(b_valid), .q_take(b_take), .q_item(b_item),
      .rsp_empty, .rsp_pop, .rsp_single_bits, .rsp_status, .rsp_end_of_matrix
   );
endmodule

@@ hdl/d2s_checker.sv @@
module d2s_checker import d2s_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_single_bits,
   input logic [1:0]  rsp_status,
   input logic        rsp_end_of_matrix
);
   // non-converted results carry zero bits
   a_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status != ST_CONVERTED |-> rsp_single_bits == 32'd0)
      else $error("nonzero bits on flagged result");
   // status code range
   a_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_status == ST_CONVERTED || rsp_status == ST_OVERFLOW
      || rsp_status == ST_SKIPPED) else $error("bad status");
   // result held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_single_bits)
      && $stable(rsp_status) && $stable(rsp_end_of_matrix))
      else $error("result changed under stall");
   // empty and not full after a reset edge
   a_rst: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("result after reset");
endmodule

bind double_to_single_convert_checked d2s_checker u_checker (.*);
